[hw/rtl/rpta_pkg.sv]
// shared types and constants for the rx power telemetry averager
// no dependencies; imported by every other file of the block
package rpta_pkg;

	localparam int CODE_W     = 8;
	localparam int MV_W       = 15;
	localparam int SAMPLE_W   = 12;
	localparam int AVG_W      = 12;
	localparam int WINDOW_LEN = 10;

	// largest scaled current sample: 255 * 25 / 2
	localparam int SAMPLE_MAX = 3187;
	localparam int SUM_W      = $clog2(WINDOW_LEN * SAMPLE_MAX + 1);

	localparam int OFFSET_RESET = 15;

	localparam logic [MV_W-1:0] RECT_SCALE = 15'd27500;
	localparam logic [MV_W-1:0] OUT_SCALE  = 15'd22500;
	// current scale 3200 / 256 reduces to 25 / 2
	localparam logic [4:0]      CUR_MULT   = 5'd25;

	// divide by the window length: sum * ceil(2^shift / len) >> shift,
	// exact for every SUM_W bit sum when shift is SUM_W + clog2(len)
	localparam int              DIV_W     = SUM_W + 1;
	localparam int              DIV_SHIFT = SUM_W + $clog2(WINDOW_LEN);
	localparam logic [DIV_W-1:0] DIV_MULT = DIV_W'(((64'd1 << DIV_SHIFT)
		+ 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

	typedef logic [CODE_W-1:0]   code_t;
	typedef logic [MV_W-1:0]     mv_t;
	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [SUM_W-1:0]    sum_t;
	typedef logic [AVG_W-1:0]    avg_t;

endpackage

[hw/rtl/rpta_if.sv]
// valid/ready channel interfaces for raw code items and telemetry items
// depends on rpta_pkg
interface rpta_in_if import rpta_pkg::*; ();
	logic  valid;
	logic  ready;
	code_t rect_voltage_code;
	code_t out_voltage_code;
	code_t out_current_code;

	modport source (output valid, rect_voltage_code, out_voltage_code, out_current_code,
		input ready);
	modport sink (input valid, rect_voltage_code, out_voltage_code, out_current_code,
		output ready);
endinterface

interface rpta_out_if import rpta_pkg::*; ();
	logic valid;
	logic ready;
	mv_t  rect_voltage_mv;
	mv_t  out_voltage_mv;
	avg_t avg_current_ma;

	modport source (output valid, rect_voltage_mv, out_voltage_mv, avg_current_ma,
		input ready);
	modport sink (input valid, rect_voltage_mv, out_voltage_mv, avg_current_ma,
		output ready);
endinterface

[hw/rtl/rpta_cell.sv]
// one sample cell of the current window shift chain
// depends on rpta_pkg
module rpta_cell import rpta_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    shift_en,
	input  sample_t d,
	output sample_t q
);

	sample_t sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift_en) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

[hw/rtl/rpta_window.sv]
// sliding window of current samples: chain of cells plus running sum
// depends on rpta_pkg and rpta_cell
module rpta_window import rpta_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    shift_en,
	input  sample_t sample_in,
	output sum_t    sum
);

	sample_t cell_q [WINDOW_LEN];
	sum_t    sum_q;

	genvar i;
	generate
		for (i = 0; i < WINDOW_LEN; i++) begin : g_cell
			if (i == 0) begin : g_head
				rpta_cell u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.shift_en (shift_en),
					.d        (sample_in),
					.q        (cell_q[i])
				);
			end else begin : g_body
				rpta_cell u_cell (
					.clk      (clk),
					.arst_n   (arst_n),
					.shift_en (shift_en),
					.d        (cell_q[i-1]),
					.q        (cell_q[i])
				);
			end
		end
	endgenerate

	// oldest sample leaves as the newest enters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (shift_en) begin
			sum_q <= sum_q - sum_t'(cell_q[WINDOW_LEN-1]) + sum_t'(sample_in);
		end
	end

	assign sum = sum_q;

endmodule

[hw/rtl/rx_power_telemetry_averager.sv]
// rx power telemetry averager: three stage pipeline, one item per cycle
// a result is offered from the stage 3 output register once its item has passed stages 1 and 2
// throughput: one item per cycle; the whole pipeline holds only while the output is stalled
// reset: clears the window cells, running sum and pipeline valids; offset returns to 15
// depends on rpta_pkg, rpta_if, rpta_window
module rx_power_telemetry_averager import rpta_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  code_t         cfg_wdata,
	rpta_in_if.sink       in_ch,
	rpta_out_if.source    out_ch
);

	// zero current offset register
	code_t offset_q;

	// stage 1: raw codes and offset-corrected current code
	logic  valid_s1;
	code_t rect_s1;
	code_t vout_s1;
	code_t net_s1;

	// stage 2: voltages in mv, window already holds this item's sample
	logic  valid_s2;
	mv_t   rect_mv_s2;
	mv_t   vout_mv_s2;

	// stage 3: output register
	logic  valid_s3;
	mv_t   rect_mv_s3;
	mv_t   vout_mv_s3;
	avg_t  avg_s3;

	logic  advance;
	logic  accept;
	logic  shift;

	sample_t                sample_s1;
	logic [CODE_W+4:0]      cur_prod;
	logic [CODE_W+MV_W-1:0] rect_prod;
	logic [CODE_W+MV_W-1:0] vout_prod;
	sum_t                   win_sum;
	logic [SUM_W+DIV_W-1:0] div_prod;

	// the pipeline moves as a whole whenever the output register is free
	assign advance     = !valid_s3 || out_ch.ready;
	assign in_ch.ready = advance;
	assign accept      = in_ch.valid && advance;
	// the window takes a sample when the stage 1 item moves to stage 2
	assign shift       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= code_t'(OFFSET_RESET);
		end else if (cfg_we) begin
			offset_q <= cfg_wdata;
		end
	end

	// scaled current: net * 3200 >> 8 == net * 25 >> 1
	assign cur_prod  = net_s1 * CUR_MULT;
	assign sample_s1 = cur_prod[SAMPLE_W:1];

	assign rect_prod = rect_s1 * RECT_SCALE;
	assign vout_prod = vout_s1 * OUT_SCALE;

	rpta_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift_en  (shift),
		.sample_in (sample_s1),
		.sum       (win_sum)
	);

	// divide by the window length through the reciprocal multiply
	assign div_prod = win_sum * DIV_MULT;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_ch.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			rect_s1 <= in_ch.rect_voltage_code;
			vout_s1 <= in_ch.out_voltage_code;
			// wraps modulo 256 when the code is below the offset
			net_s1  <= in_ch.out_current_code - offset_q;
		end
		if (shift) begin
			rect_mv_s2 <= rect_prod[CODE_W+MV_W-1:CODE_W];
			vout_mv_s2 <= vout_prod[CODE_W+MV_W-1:CODE_W];
		end
		if (valid_s2 && advance) begin
			rect_mv_s3 <= rect_mv_s2;
			vout_mv_s3 <= vout_mv_s2;
			avg_s3     <= div_prod[DIV_SHIFT+AVG_W-1:DIV_SHIFT];
		end
	end

	assign out_ch.valid           = valid_s3;
	assign out_ch.rect_voltage_mv = rect_mv_s3;
	assign out_ch.out_voltage_mv  = vout_mv_s3;
	assign out_ch.avg_current_ma  = avg_s3;

endmodule

[hw/rtl/rpta_checker.sv]
// port level checks for the rx power telemetry averager, bound to the top level
// depends on rpta_pkg and rx_power_telemetry_averager
module rpta_checker import rpta_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input mv_t  rect_voltage_mv,
	input mv_t  out_voltage_mv,
	input avg_t avg_current_ma
);

	// a stalled result item stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	// a stalled result item keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(rect_voltage_mv) && $stable(out_voltage_mv)
			&& $stable(avg_current_ma))
		else $error("result payload changed while stalled");

	// an empty output register never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// an accepted item reaches the output when no backpressure holds it on its way
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("accepted item did not reach the output");

	// results stay within the scaled ranges
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (avg_current_ma <= avg_t'(SAMPLE_MAX)) && (rect_voltage_mv <= 15'd27392)
			&& (out_voltage_mv <= 15'd22412))
		else $error("result out of range");

endmodule

bind rx_power_telemetry_averager rpta_checker u_rpta_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_ch.valid),
	.in_ready        (in_ch.ready),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.rect_voltage_mv (out_ch.rect_voltage_mv),
	.out_voltage_mv  (out_ch.out_voltage_mv),
	.avg_current_ma  (out_ch.avg_current_ma)
);

[verif/rpta_telemetry_checker.sv]
`timescale 1ns / 1ps
// telemetry checker: predicts each telemetry item from the accepted raw code items
// and compares it field by field; depends on rpta_pkg and rpta_if
module rpta_telemetry_checker import rpta_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_we,
	input  code_t cfg_wdata,
	rpta_in_if    in_mon,
	rpta_out_if   out_mon,
	output int    fail_count,
	output int    outstanding
);

	localparam int CURRENT_SCALE = 25 * 128;

	typedef struct packed {
		mv_t  rect_voltage_mv;
		mv_t  out_voltage_mv;
		avg_t avg_current_ma;
	} telemetry_t;

	code_t      zero_offset;
	sample_t    current_window [WINDOW_LEN];
	logic [16:0] window_total;
	telemetry_t expected_telemetry_q [$];
	int         mismatch_count = 0;

	// advances the sliding window by one sample and returns the telemetry item
	function automatic telemetry_t predict_telemetry(code_t rect_code, code_t vout_code,
		code_t cur_code);
		telemetry_t t;
		code_t      net_code;
		sample_t    sample;
		net_code = cur_code - zero_offset;
		sample = sample_t'((32'(net_code) * CURRENT_SCALE) >> 8);
		window_total = window_total - 17'(current_window[WINDOW_LEN-1]) + 17'(sample);
		for (int i = WINDOW_LEN - 1; i > 0; i--)
			current_window[i] = current_window[i-1];
		current_window[0] = sample;
		t.rect_voltage_mv = mv_t'((32'(rect_code) * 32'(RECT_SCALE)) >> 8);
		t.out_voltage_mv  = mv_t'((32'(vout_code) * 32'(OUT_SCALE)) >> 8);
		t.avg_current_ma  = avg_t'(window_total / WINDOW_LEN);
		return t;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		telemetry_t got;
		telemetry_t want;
		if (!arst_n) begin
			zero_offset = code_t'(OFFSET_RESET);
			foreach (current_window[i])
				current_window[i] = '0;
			window_total = '0;
			expected_telemetry_q.delete();
			outstanding <= 0;
			fail_count <= mismatch_count;
		end else begin
			if (in_mon.valid && in_mon.ready)
				expected_telemetry_q.push_back(predict_telemetry(in_mon.rect_voltage_code,
					in_mon.out_voltage_code, in_mon.out_current_code));
			if (out_mon.valid && out_mon.ready) begin
				got.rect_voltage_mv = out_mon.rect_voltage_mv;
				got.out_voltage_mv  = out_mon.out_voltage_mv;
				got.avg_current_ma  = out_mon.avg_current_ma;
				if (expected_telemetry_q.size() == 0) begin
					$error("telemetry item with none expected: rect_voltage_mv %0d out_voltage_mv %0d avg_current_ma %0d",
						got.rect_voltage_mv, got.out_voltage_mv, got.avg_current_ma);
					mismatch_count++;
				end else begin
					want = expected_telemetry_q.pop_front();
					if (got.rect_voltage_mv !== want.rect_voltage_mv) begin
						$error("rect_voltage_mv: expected %0d, actual %0d",
							want.rect_voltage_mv, got.rect_voltage_mv);
						mismatch_count++;
					end
					if (got.out_voltage_mv !== want.out_voltage_mv) begin
						$error("out_voltage_mv: expected %0d, actual %0d",
							want.out_voltage_mv, got.out_voltage_mv);
						mismatch_count++;
					end
					if (got.avg_current_ma !== want.avg_current_ma) begin
						$error("avg_current_ma: expected %0d, actual %0d",
							want.avg_current_ma, got.avg_current_ma);
						mismatch_count++;
					end
				end
			end
			// a register write lands after any item taken on the same edge
			if (cfg_we)
				zero_offset = cfg_wdata;
			outstanding <= expected_telemetry_q.size();
			fail_count <= mismatch_count;
		end
	end

endmodule

[verif/tb_rx_power_telemetry_averager.sv]
`timescale 1ns / 1ps
// testbench top for the rx power telemetry averager: clock, reset, stimulus and verdict
// depends on rpta_pkg, rpta_if, the block and rpta_telemetry_checker
module tb_rx_power_telemetry_averager;
	import rpta_pkg::*;

	// far above the slowest correct run
	localparam int CYCLE_LIMIT   = 200000;
	// long enough that the three stage pipeline fills and stalls its input
	localparam int LONG_HOLD     = 96;
	// settle time after the last result
	localparam int SETTLE_CYCLES = 12;
	localparam int SEGMENTS      = 9;
	localparam int SEGMENT_ITEMS = 148;

	logic  clk;
	logic  arst_n;
	logic  cfg_we;
	code_t cfg_wdata;

	// idle percentages of sender and receiver, changed between segments
	int    send_idle_pct;
	int    recv_idle_pct;
	// one long receiver hold-off, asked by the stimulus and timed by the receiver
	logic  hold_req;
	code_t active_offset;
	int    cycle_count = 0;
	int    fail_count;
	int    outstanding;

	rpta_in_if  in_ch();
	rpta_out_if out_ch();

	rx_power_telemetry_averager i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	rpta_telemetry_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_mon      (in_ch),
		.out_mon     (out_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random ready, plus one long hold-off counted here
	initial begin : receiver
		logic hold_done;
		int   held;
		hold_done = 1'b0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				// sender keeps offering items meanwhile, so the input backs up
				out_ch.ready <= 1'b0;
				for (held = 0; held < LONG_HOLD; held++)
					@(posedge clk);
				hold_done = 1'b1;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// offer one item, with random gaps before it, and wait until it is taken
	task automatic send_codes(code_t rect_code, code_t vout_code, code_t cur_code);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid             <= 1'b1;
		in_ch.rect_voltage_code <= rect_code;
		in_ch.out_voltage_code  <= vout_code;
		in_ch.out_current_code  <= cur_code;
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	// random item; the current code often sits at the offset or just around it
	task automatic send_random_item();
		code_t rect_code;
		code_t vout_code;
		code_t cur_code;
		rect_code = ($urandom_range(0, 7) == 0) ? {8{1'($urandom_range(0, 1))}}
			: code_t'($urandom_range(0, 255));
		vout_code = ($urandom_range(0, 7) == 0) ? {8{1'($urandom_range(0, 1))}}
			: code_t'($urandom_range(0, 255));
		case ($urandom_range(0, 7))
			0: begin
				// one below, at, or one above the offset: the wrap boundary
				cur_code = active_offset + code_t'($urandom_range(0, 2)) - 8'd1;
			end
			1: begin
				cur_code = {8{1'($urandom_range(0, 1))}};
			end
			default: begin
				cur_code = code_t'($urandom_range(0, 255));
			end
		endcase
		send_codes(rect_code, vout_code, cur_code);
	endtask

	// stop offering and wait until every telemetry item has come back
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// offset register is only written with the pipeline empty
	task automatic write_offset(code_t value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_offset = value;
	endtask

	initial begin : stimulus
		code_t offset_plan [SEGMENTS];
		int    seg;
		int    n;
		int    b;
		in_ch.valid             <= 1'b0;
		in_ch.rect_voltage_code <= '0;
		in_ch.out_voltage_code  <= '0;
		in_ch.out_current_code  <= '0;
		cfg_we                  <= 1'b0;
		cfg_wdata               <= '0;
		hold_req                <= 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		active_offset = code_t'(OFFSET_RESET);
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset offset; the first nine items also show the warm-up
		// averages, with zeros still filling the window
		send_codes(8'd0, 8'd0, 8'd0);        // current below offset wraps large
		send_codes(8'd255, 8'd255, 8'd255);
		send_codes(8'd0, 8'd0, 8'd15);       // exactly at the offset
		send_codes(8'd0, 8'd0, 8'd14);       // one below the offset
		send_codes(8'd0, 8'd0, 8'd16);
		for (b = 0; b < 8; b++)
			send_codes(code_t'(1 << b), ~code_t'(1 << b), ~code_t'(1 << b));

		// offset extremes
		write_offset(8'd0);
		send_codes(8'd0, 8'd0, 8'd0);
		send_codes(8'd255, 8'd255, 8'd255);
		send_codes(8'd128, 8'd127, 8'd1);
		write_offset(8'd255);
		send_codes(8'd0, 8'd0, 8'd0);        // net one
		send_codes(8'd10, 8'd20, 8'd254);    // net 255, largest sample
		send_codes(8'd255, 8'd255, 8'd255);  // net zero

		// offsets for the random segments, extremes among them
		offset_plan = '{8'd0, 8'd255, 8'd0, 8'd15, 8'd128, 8'd0, 8'd255, 8'd0, 8'd0};
		foreach (offset_plan[i])
			if (i % 3 == 2)
				offset_plan[i] = code_t'($urandom_range(0, 255));

		// three idle modes, three offset settings in each
		for (seg = 0; seg < SEGMENTS; seg++) begin
			case (seg / 3)
				0: begin
					send_idle_pct = 32;
					recv_idle_pct = 76;
				end
				1: begin
					send_idle_pct = 76;
					recv_idle_pct = 32;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_offset(offset_plan[seg]);
			for (n = 0; n < SEGMENT_ITEMS; n++) begin
				if (seg == 0 && n == 40)
					hold_req <= 1'b1;
				// sender pause mid-stream until the pipeline is empty
				if (seg == 4 && n == 70)
					drain_results();
				send_random_item();
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
